/* rtl/dac_pkg.sv */
// ----------------------------------------------------------------------------
// dac_pkg: door access controller shared definitions
// Mode, event and cue codes, register indexes, payload types and the
// event queue sizing used by the controller and its event queue.
// ----------------------------------------------------------------------------
package dac_pkg;

   // event queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW          = $clog2(QUEUE_DEPTH + 1);
   // at most six events are raised in one tick
   localparam int NPUSH       = 6;
   localparam int PCW         = $clog2(NPUSH + 1);
   // wide enough for pointer sums, counts and offsets
   localparam int SW          = $clog2(2 * QUEUE_DEPTH + NPUSH);

   // configuration registers
   localparam int NREG = 8;
   localparam int RIW  = 3;
   localparam int RDW  = 24;

   localparam logic [RIW-1:0] REG_LOCK_DELAY   = 3'd0;
   localparam logic [RIW-1:0] REG_DOOR_WAIT    = 3'd1;
   localparam logic [RIW-1:0] REG_DENY_HOLD    = 3'd2;
   localparam logic [RIW-1:0] REG_OPEN_TIMEOUT = 3'd3;
   localparam logic [RIW-1:0] REG_SETTLE       = 3'd4;
   localparam logic [RIW-1:0] REG_SETTLE_MAX   = 3'd5;
   localparam logic [RIW-1:0] REG_HEARTBEAT    = 3'd6;
   localparam logic [RIW-1:0] REG_PUBLISH      = 3'd7;

   // controller modes
   localparam logic [2:0] M_IDLE    = 3'd0;
   localparam logic [2:0] M_GRANTED = 3'd1;
   localparam logic [2:0] M_DENIED  = 3'd2;
   localparam logic [2:0] M_TEMP    = 3'd3;
   localparam logic [2:0] M_ALARM   = 3'd4;

   // event codes
   localparam logic [2:0] E_GRANT     = 3'd0;
   localparam logic [2:0] E_DENY      = 3'd1;
   localparam logic [2:0] E_OPEN      = 3'd2;
   localparam logic [2:0] E_CLOSED    = 3'd3;
   localparam logic [2:0] E_ALARM_ON  = 3'd4;
   localparam logic [2:0] E_ALARM_OFF = 3'd5;
   localparam logic [2:0] E_STATUS    = 3'd6;
   localparam logic [2:0] E_REMOTE    = 3'd7;

   // sound cues
   localparam logic [1:0] CUE_NONE    = 2'd0;
   localparam logic [1:0] CUE_CONFIRM = 2'd1;
   localparam logic [1:0] CUE_ERROR   = 2'd2;

   // push slots in the order events are raised within a tick
   localparam int SLOT_DOOR   = 0;
   localparam int SLOT_CARD   = 1;
   localparam int SLOT_ALARM  = 2;
   localparam int SLOT_REMOTE = 3;
   localparam int SLOT_STATUS = 4;
   localparam int SLOT_BEAT   = 5;

   typedef struct packed {
      logic        door_open;
      logic        card_present;
      logic        card_valid;
      logic [31:0] card_id;
      logic        button_press;
      logic        remote_open;
      logic        status_request;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        settling;
      logic        lock_released;
      logic [1:0]  sound_cue;
      logic        publish_valid;
      logic [2:0]  publish_event;
      logic [2:0]  publish_mode;
      logic [31:0] publish_card;
      logic        queue_dropped;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [2:0]  mode;
      logic [31:0] card;
   } event_type;

   // controller to queue
   typedef struct packed {
      logic                   step;
      logic                   pop_due;
      logic [NPUSH-1:0]       push_valid;
      event_type [NPUSH-1:0]  push_event;
   } queue_ctrl_type;

   // queue to controller
   typedef struct packed {
      logic      pop_valid;
      event_type pop_event;
      logic      dropped;
   } queue_stat_type;

   // reset value of each configuration register
   function automatic logic [RDW-1:0] cfg_reset_value(input logic [RIW-1:0] idx);
      logic [RDW-1:0] val;
      unique case (idx)
         REG_LOCK_DELAY:   val = 24'd1000;
         REG_DOOR_WAIT:    val = 24'd10000;
         REG_DENY_HOLD:    val = 24'd3000;
         REG_OPEN_TIMEOUT: val = 24'd10000;
         REG_SETTLE:       val = 24'd2000;
         REG_SETTLE_MAX:   val = 24'd5000;
         REG_HEARTBEAT:    val = 24'd60000;
         REG_PUBLISH:      val = 24'd1200;
         default:          val = 24'd1200;
      endcase
      return val;
   endfunction

endpackage

/* rtl/dac_event_queue.sv */
// ----------------------------------------------------------------------------
// dac_event_queue: circular event queue
// Takes up to NPUSH events per tick in slot order, drops what does not fit,
// and pops one entry when a publish is due.
// ----------------------------------------------------------------------------
module dac_event_queue
   import dac_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_ctrl_type ctrl_in,
   output queue_stat_type stat_out
);

   event_type          entries_ff [QUEUE_DEPTH];
   logic [QW-1:0]      head_ff, head_in;
   logic [QW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;

   event_type          compact [NPUSH];
   logic [PCW-1:0]     num_push;
   logic [SW-1:0]      free_slots;
   logic [SW-1:0]      accepted;
   logic [SW-1:0]      count_after;
   logic [SW-1:0]      tail_sum;
   logic [SW-1:0]      offset [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] wr_en;
   logic [PCW-1:0]     wr_sel [QUEUE_DEPTH];
   logic               pop;

   // pack the raised events into consecutive positions
   always_comb begin
      num_push = '0;
      for (int j = 0; j < NPUSH; j++) begin
         compact[j] = '0;
      end
      for (int j = 0; j < NPUSH; j++) begin
         if (ctrl_in.push_valid[j]) begin
            compact[num_push] = ctrl_in.push_event[j];
            num_push          = num_push + 1'b1;
         end
      end
   end

   // how many fit, and where each one lands
   always_comb begin
      free_slots  = SW'(QUEUE_DEPTH) - SW'(count_ff);
      accepted    = (SW'(num_push) < free_slots) ? SW'(num_push) : free_slots;
      count_after = SW'(count_ff) + accepted;
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
         if (QW'(e) >= tail_ff) begin
            offset[e] = SW'(e) - SW'(tail_ff);
         end else begin
            offset[e] = SW'(e) + SW'(QUEUE_DEPTH) - SW'(tail_ff);
         end
         wr_en[e]  = ctrl_in.step && (offset[e] < accepted);
         wr_sel[e] = offset[e][PCW-1:0];
      end
   end

   // pointer and count updates
   always_comb begin
      pop      = ctrl_in.step && ctrl_in.pop_due && (count_after != '0);
      tail_sum = SW'(tail_ff) + accepted;
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      end
      tail_in  = ctrl_in.step ? tail_sum[QW-1:0] : tail_ff;
      count_in = ctrl_in.step ? CW'(count_after - SW'(pop)) : count_ff;
      if (pop) begin
         head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end else begin
         head_in = head_ff;
      end
   end

   // popped entry: an empty queue hands over the first event of this tick
   always_comb begin
      stat_out.pop_valid = pop;
      stat_out.dropped   = ctrl_in.step && (SW'(num_push) > free_slots);
      if (!pop) begin
         stat_out.pop_event = '0;
      end else if (count_ff == '0) begin
         stat_out.pop_event = compact[0];
      end else begin
         stat_out.pop_event = entries_ff[head_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
         if (wr_en[e]) begin
            entries_ff[e] <= compact[wr_sel[e]];
         end
      end
   end

endmodule

/* rtl/door_access_controller.sv */
// ----------------------------------------------------------------------------
// door_access_controller: door access controller top level
// Millisecond tick driven access control with event queue and publishing.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one millisecond tick carrying the door
// contact, card reader and command inputs. Each request yields exactly one
// response on the rsp_ channel with the mode, lock and cue outputs and the
// event popped for publishing, if any.
// Requests pass through an input register and a response register; a
// response is registered as its request leaves the input register.
// One request is taken every cycle while req_stall is low; all mode, timer
// and queue work for a tick fits in the single pass between the registers.
// A stalled response holds in its register; the input register still takes
// a request while the response register is empty or being emptied, and
// req_stall rises only when both stages are full and rsp_stall is high.
// Timer registers are written through the csr_ port, which is always ready;
// write them only while no request is in flight.
// Synchronous reset returns the mode to idle, clears all timers, flags and
// the queue, and restores the register defaults. The first tick after reset
// always queues a door open or door closed event.
// ----------------------------------------------------------------------------
module door_access_controller
   import dac_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [RIW-1:0] csr_index,
   input  logic [RDW-1:0] csr_data
);

   // pipeline registers
   logic           req_valid_ff;
   req_type        req_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           adv_out, adv_in, step;

   // configuration
   logic [RDW-1:0] cfg_ff [NREG];

   // controller state
   logic [2:0]  mode_ff, mode_in;
   logic        settle_ff, settle_in;
   logic        lock_ff, lock_in;
   logic        opened_ff, opened_in;
   logic        by_button_ff, by_button_in;
   logic        pending_ff, pending_in;
   logic        prev_door_ff, prev_door_in;
   logic        door_known_ff, door_known_in;
   logic [31:0] now_ff;
   logic [31:0] entry_ff, entry_in;
   logic [31:0] lock_time_ff, lock_time_in;
   logic [31:0] settle_start_ff, settle_start_in;
   logic [31:0] last_beat_ff, last_beat_in;
   logic [31:0] last_pub_ff, last_pub_in;
   logic [31:0] last_card_ff, last_card_in;

   logic [1:0]     cue;
   logic [31:0]    settle_el;
   queue_ctrl_type qctrl;
   queue_stat_type qstat;

   // handshake
   assign adv_out   = !rsp_valid_ff || !rsp_stall;
   assign adv_in    = !req_valid_ff || adv_out;
   assign step      = req_valid_ff && adv_out;
   assign req_stall = !adv_in;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREG; i++) begin
            cfg_ff[i] <= cfg_reset_value(RIW'(i));
         end
      end else if (csr_valid) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // tick logic: door edge, settle hold or mode step, commands, heartbeat
   always_comb begin
      mode_in         = mode_ff;
      settle_in       = settle_ff;
      lock_in         = lock_ff;
      opened_in       = opened_ff;
      by_button_in    = by_button_ff;
      pending_in      = pending_ff;
      prev_door_in    = prev_door_ff;
      door_known_in   = door_known_ff;
      entry_in        = entry_ff;
      lock_time_in    = lock_time_ff;
      settle_start_in = settle_start_ff;
      last_beat_in    = last_beat_ff;
      last_pub_in     = last_pub_ff;
      last_card_in    = last_card_ff;
      cue             = CUE_NONE;
      qctrl           = '0;
      qctrl.step      = step;
      settle_el       = now_ff - settle_start_ff;

      // door contact change
      if (!door_known_ff || (req_ff.door_open != prev_door_ff)) begin
         prev_door_in  = req_ff.door_open;
         door_known_in = 1'b1;
         qctrl.push_valid[SLOT_DOOR] = 1'b1;
         qctrl.push_event[SLOT_DOOR] = '{code: req_ff.door_open ? E_OPEN : E_CLOSED,
                                         mode: mode_ff, card: 32'd0};
      end

      if (settle_ff) begin
         // stabilisation hold
         if (settle_el >= 32'(cfg_ff[REG_SETTLE])
             || settle_el > 32'(cfg_ff[REG_SETTLE_MAX])) begin
            settle_in = 1'b0;
         end
      end else begin
         unique case (mode_ff)
            M_IDLE: begin
               if (pending_ff) begin
                  pending_in   = 1'b0;
                  by_button_in = 1'b0;
                  mode_in      = M_TEMP;
                  entry_in     = now_ff;
               end else begin
                  // card, then button, then forced door; later ones win
                  if (req_ff.card_present) begin
                     last_card_in = req_ff.card_id;
                     qctrl.push_valid[SLOT_CARD] = 1'b1;
                     entry_in = now_ff;
                     if (req_ff.card_valid) begin
                        cue       = CUE_CONFIRM;
                        lock_in   = 1'b0;
                        opened_in = 1'b0;
                        mode_in   = M_GRANTED;
                        qctrl.push_event[SLOT_CARD] = '{code: E_GRANT, mode: M_GRANTED,
                                                        card: req_ff.card_id};
                     end else begin
                        cue     = CUE_ERROR;
                        mode_in = M_DENIED;
                        qctrl.push_event[SLOT_CARD] = '{code: E_DENY, mode: M_DENIED,
                                                        card: req_ff.card_id};
                     end
                  end
                  if (req_ff.button_press) begin
                     by_button_in = 1'b0;
                     mode_in      = M_TEMP;
                     entry_in     = now_ff;
                  end
                  if (req_ff.door_open) begin
                     mode_in  = M_ALARM;
                     entry_in = now_ff;
                     qctrl.push_valid[SLOT_ALARM] = 1'b1;
                     qctrl.push_event[SLOT_ALARM] = '{code: E_ALARM_ON, mode: M_ALARM,
                                                      card: 32'd0};
                  end
               end
            end
            M_GRANTED: begin
               if (!lock_ff && (now_ff - entry_ff) >= 32'(cfg_ff[REG_LOCK_DELAY])) begin
                  lock_in      = 1'b1;
                  lock_time_in = now_ff;
                  opened_in    = 1'b0;
               end
               if (lock_in) begin
                  if (req_ff.door_open) begin
                     opened_in = 1'b1;
                  end
                  if (opened_in && !req_ff.door_open) begin
                     // door closed after the access: start the hold
                     lock_in         = 1'b0;
                     opened_in       = 1'b0;
                     settle_in       = 1'b1;
                     settle_start_in = now_ff;
                     mode_in         = M_IDLE;
                     entry_in        = now_ff;
                  end else if (!opened_in
                               && (now_ff - lock_time_in) >= 32'(cfg_ff[REG_DOOR_WAIT])) begin
                     lock_in  = 1'b0;
                     mode_in  = M_IDLE;
                     entry_in = now_ff;
                  end
               end
            end
            M_DENIED: begin
               if ((now_ff - entry_ff) >= 32'(cfg_ff[REG_DENY_HOLD])) begin
                  mode_in  = M_IDLE;
                  entry_in = now_ff;
               end
               if (req_ff.door_open) begin
                  mode_in  = M_ALARM;
                  entry_in = now_ff;
                  qctrl.push_valid[SLOT_ALARM] = 1'b1;
                  qctrl.push_event[SLOT_ALARM] = '{code: E_ALARM_ON, mode: M_ALARM,
                                                   card: last_card_ff};
               end
            end
            M_TEMP: begin
               if (req_ff.door_open) begin
                  by_button_in = 1'b1;
               end
               if (by_button_in && !req_ff.door_open) begin
                  by_button_in    = 1'b0;
                  settle_in       = 1'b1;
                  settle_start_in = now_ff;
                  mode_in         = M_IDLE;
                  entry_in        = now_ff;
               end else if ((now_ff - entry_ff) >= 32'(cfg_ff[REG_OPEN_TIMEOUT])) begin
                  by_button_in = 1'b0;
                  mode_in      = M_IDLE;
                  entry_in     = now_ff;
               end
            end
            M_ALARM: begin
               if (!req_ff.door_open) begin
                  mode_in  = M_IDLE;
                  entry_in = now_ff;
                  qctrl.push_valid[SLOT_ALARM] = 1'b1;
                  qctrl.push_event[SLOT_ALARM] = '{code: E_ALARM_OFF, mode: M_IDLE,
                                                   card: 32'd0};
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase
      end

      // remote commands
      if (req_ff.remote_open) begin
         qctrl.push_valid[SLOT_REMOTE] = 1'b1;
         qctrl.push_event[SLOT_REMOTE] = '{code: E_REMOTE, mode: mode_in, card: 32'd0};
         if (mode_in == M_IDLE) begin
            pending_in = 1'b1;
         end
      end
      if (req_ff.status_request) begin
         qctrl.push_valid[SLOT_STATUS] = 1'b1;
         qctrl.push_event[SLOT_STATUS] = '{code: E_STATUS, mode: mode_in, card: 32'd0};
      end

      // heartbeat, not while in alarm
      if (mode_in != M_ALARM && (now_ff - last_beat_ff) >= 32'(cfg_ff[REG_HEARTBEAT])) begin
         last_beat_in = now_ff;
         qctrl.push_valid[SLOT_BEAT] = 1'b1;
         qctrl.push_event[SLOT_BEAT] = '{code: E_STATUS, mode: mode_in, card: 32'd0};
      end

      // publish interval
      if ((now_ff - last_pub_ff) >= 32'(cfg_ff[REG_PUBLISH])) begin
         last_pub_in   = now_ff;
         qctrl.pop_due = 1'b1;
      end
   end

   dac_event_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (qctrl),
      .stat_out (qstat)
   );

   // response contents
   always_comb begin
      rsp_in.mode          = mode_in;
      rsp_in.settling      = settle_in;
      rsp_in.lock_released = lock_in;
      rsp_in.sound_cue     = cue;
      rsp_in.publish_valid = qstat.pop_valid;
      rsp_in.publish_event = qstat.pop_event.code;
      rsp_in.publish_mode  = qstat.pop_event.mode;
      rsp_in.publish_card  = qstat.pop_event.card;
      rsp_in.queue_dropped = qstat.dropped;
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (adv_in) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         req_ff <= req_data;
      end
   end

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   // controller state, advanced once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= M_IDLE;
         settle_ff       <= 1'b0;
         lock_ff         <= 1'b0;
         opened_ff       <= 1'b0;
         by_button_ff    <= 1'b0;
         pending_ff      <= 1'b0;
         prev_door_ff    <= 1'b0;
         door_known_ff   <= 1'b0;
         now_ff          <= '0;
         entry_ff        <= '0;
         lock_time_ff    <= '0;
         settle_start_ff <= '0;
         last_beat_ff    <= '0;
         last_pub_ff     <= '0;
         last_card_ff    <= '0;
      end else if (step) begin
         mode_ff         <= mode_in;
         settle_ff       <= settle_in;
         lock_ff         <= lock_in;
         opened_ff       <= opened_in;
         by_button_ff    <= by_button_in;
         pending_ff      <= pending_in;
         prev_door_ff    <= prev_door_in;
         door_known_ff   <= door_known_in;
         now_ff          <= now_ff + 32'd1;
         entry_ff        <= entry_in;
         lock_time_ff    <= lock_time_in;
         settle_start_ff <= settle_start_in;
         last_beat_ff    <= last_beat_in;
         last_pub_ff     <= last_pub_in;
         last_card_ff    <= last_card_in;
      end
   end

endmodule

/* rtl/dac_checker.sv */
// ----------------------------------------------------------------------------
// dac_checker: response port checks for the door access controller
// Watches the response channel and flags inconsistent outputs.
// ----------------------------------------------------------------------------
module dac_checker
   import dac_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no publish means empty publish fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.publish_valid |->
         rsp_data.publish_event == E_GRANT && rsp_data.publish_mode == M_IDLE
         && rsp_data.publish_card == 32'd0)
      else $error("publish fields set without a publish");

   // lock only released in granted mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lock_released |-> rsp_data.mode == M_GRANTED)
      else $error("lock released outside granted mode");

   // stabilisation hold only in idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.settling |-> rsp_data.mode == M_IDLE)
      else $error("settling outside idle mode");

endmodule

bind door_access_controller dac_checker u_dac_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* verif/dac_tick_checker.sv */
// ----------------------------------------------------------------------------
// dac_tick_checker: response checker for the door access controller
// Watches the request, response and register channels, keeps its own copy
// of the controller state and timers, works out the response of every
// accepted tick and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module dac_tick_checker
   import dac_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_stall,
   input  req_type        req_data,
   input  logic           rsp_valid,
   input  logic           rsp_stall,
   input  rsp_type        rsp_data,
   input  logic           csr_valid,
   input  logic           csr_ready,
   input  logic [RIW-1:0] csr_index,
   input  logic [RDW-1:0] csr_data,
   output int             fail_count,
   output int             waiting,
   output int             checked,
   output int             published,
   output int             dropped_ticks
);

   // timer values after reset, by register index
   localparam logic [RDW-1:0] TIMER_DEFAULT [NREG] = '{
      24'd1000, 24'd10000, 24'd3000, 24'd10000, 24'd2000, 24'd5000, 24'd60000, 24'd1200
   };

   // local copy of the controller
   logic [RDW-1:0] timer [NREG];
   logic [2:0]     mode_q;
   logic           settling_q, lock_q, door_cycled, by_button, remote_armed;
   logic           last_door, door_seen, lost;
   logic [31:0]    clock_ms, entered_at, lock_at, settle_t0, last_beat, last_pub, card_seen;
   event_type      event_fifo [QUEUE_DEPTH];
   int             head_idx, tail_idx, fill;

   // responses still owed by the block, oldest first
   rsp_type        predicted_ticks [$];

   function automatic void clear_model();
      for (int i = 0; i < NREG; i++) timer[i] = TIMER_DEFAULT[i];
      mode_q       = M_IDLE;
      settling_q   = 1'b0;
      lock_q       = 1'b0;
      door_cycled  = 1'b0;
      by_button    = 1'b0;
      remote_armed = 1'b0;
      last_door    = 1'b0;
      door_seen    = 1'b0;
      lost         = 1'b0;
      clock_ms     = '0;
      entered_at   = '0;
      lock_at      = '0;
      settle_t0    = '0;
      last_beat    = '0;
      last_pub     = '0;
      card_seen    = '0;
      head_idx     = 0;
      tail_idx     = 0;
      fill         = 0;
   endfunction

   // a full queue loses the new event and flags the tick
   function automatic void queue_event(input logic [2:0] ev_code, input logic [31:0] ev_card,
                                       input logic [2:0] ev_mode);
      if (fill >= QUEUE_DEPTH) begin
         lost = 1'b1;
      end else begin
         event_fifo[tail_idx] = '{code: ev_code, mode: ev_mode, card: ev_card};
         tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
         fill++;
      end
   endfunction

   function automatic void enter_mode(input logic [2:0] next, input logic [31:0] now);
      if (next != mode_q) begin
         mode_q     = next;
         entered_at = now;
      end
   endfunction

   function automatic void begin_settle(input logic [31:0] now);
      settling_q = 1'b1;
      settle_t0  = now;
      enter_mode(M_IDLE, now);
   endfunction

   // one millisecond tick of the controller
   function automatic rsp_type run_tick(input req_type r);
      logic [31:0] now;
      logic [1:0]  cue;
      rsp_type     res;
      now  = clock_ms;
      cue  = CUE_NONE;
      res  = '0;
      lost = 1'b0;

      // door contact edge, always reported on the first tick
      if (!door_seen || r.door_open != last_door) begin
         last_door = r.door_open;
         door_seen = 1'b1;
         queue_event(r.door_open ? E_OPEN : E_CLOSED, 32'd0, mode_q);
      end

      // stabilisation hold or the mode logic
      if (settling_q) begin
         if (now - settle_t0 >= timer[REG_SETTLE]) settling_q = 1'b0;
         else if (now - settle_t0 > timer[REG_SETTLE_MAX]) settling_q = 1'b0;
      end else begin
         case (mode_q)
            M_IDLE: begin
               if (remote_armed) begin
                  remote_armed = 1'b0;
                  by_button    = 1'b0;
                  enter_mode(M_TEMP, now);
               end else begin
                  // card, button then forced door: the later one wins
                  if (r.card_present) begin
                     card_seen = r.card_id;
                     if (r.card_valid) begin
                        cue = CUE_CONFIRM;
                        queue_event(E_GRANT, r.card_id, M_GRANTED);
                        lock_q      = 1'b0;
                        door_cycled = 1'b0;
                        enter_mode(M_GRANTED, now);
                     end else begin
                        cue = CUE_ERROR;
                        queue_event(E_DENY, r.card_id, M_DENIED);
                        enter_mode(M_DENIED, now);
                     end
                  end
                  if (r.button_press) begin
                     by_button = 1'b0;
                     enter_mode(M_TEMP, now);
                  end
                  if (r.door_open) begin
                     enter_mode(M_ALARM, now);
                     queue_event(E_ALARM_ON, 32'd0, M_ALARM);
                  end
               end
            end
            M_GRANTED: begin
               if (!lock_q && now - entered_at >= timer[REG_LOCK_DELAY]) begin
                  lock_q      = 1'b1;
                  lock_at     = now;
                  door_cycled = 1'b0;
               end
               if (lock_q) begin
                  if (r.door_open) door_cycled = 1'b1;
                  if (door_cycled && !r.door_open) begin
                     lock_q      = 1'b0;
                     door_cycled = 1'b0;
                     begin_settle(now);
                  end else if (!door_cycled && now - lock_at >= timer[REG_DOOR_WAIT]) begin
                     lock_q = 1'b0;
                     enter_mode(M_IDLE, now);
                  end
               end
            end
            M_DENIED: begin
               if (now - entered_at >= timer[REG_DENY_HOLD]) enter_mode(M_IDLE, now);
               if (r.door_open) begin
                  queue_event(E_ALARM_ON, card_seen, M_ALARM);
                  enter_mode(M_ALARM, now);
               end
            end
            M_TEMP: begin
               if (r.door_open) by_button = 1'b1;
               if (by_button && !r.door_open) begin
                  by_button = 1'b0;
                  begin_settle(now);
               end else if (now - entered_at >= timer[REG_OPEN_TIMEOUT]) begin
                  by_button = 1'b0;
                  enter_mode(M_IDLE, now);
               end
            end
            M_ALARM: begin
               if (!r.door_open) begin
                  queue_event(E_ALARM_OFF, 32'd0, M_IDLE);
                  enter_mode(M_IDLE, now);
               end
            end
            default: begin
               mode_q = M_IDLE;
            end
         endcase
      end

      // remote commands: a remote open only arms in idle
      if (r.remote_open) begin
         queue_event(E_REMOTE, 32'd0, mode_q);
         if (mode_q == M_IDLE) remote_armed = 1'b1;
      end
      if (r.status_request) queue_event(E_STATUS, 32'd0, mode_q);

      // heartbeat, held off in alarm
      if (mode_q != M_ALARM && now - last_beat >= timer[REG_HEARTBEAT]) begin
         last_beat = now;
         queue_event(E_STATUS, 32'd0, mode_q);
      end

      // publish pops at most one event
      if (now - last_pub >= timer[REG_PUBLISH]) begin
         last_pub = now;
         if (fill > 0) begin
            res.publish_valid = 1'b1;
            res.publish_event = event_fifo[head_idx].code;
            res.publish_mode  = event_fifo[head_idx].mode;
            res.publish_card  = event_fifo[head_idx].card;
            head_idx = (head_idx + 1) % QUEUE_DEPTH;
            fill--;
         end
      end

      res.mode          = mode_q;
      res.settling      = settling_q;
      res.lock_released = lock_q;
      res.sound_cue     = cue;
      res.queue_dropped = lost;
      clock_ms = now + 32'd1;
      return res;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("response %0d, %s: expected %0h, got %0h", checked, label, want, got);
         fail_count++;
      end
   endfunction

   // track the channels at every rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_model();
         predicted_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) timer[csr_index] = csr_data;
         if (req_valid && !req_stall) begin
            want = run_tick(req_data);
            if (want.publish_valid) published++;
            if (want.queue_dropped) dropped_ticks++;
            predicted_ticks.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_ticks.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = predicted_ticks.pop_front();
               check_field("mode", 32'(want.mode), 32'(rsp_data.mode));
               check_field("settling", 32'(want.settling), 32'(rsp_data.settling));
               check_field("lock_released", 32'(want.lock_released),
                           32'(rsp_data.lock_released));
               check_field("sound_cue", 32'(want.sound_cue), 32'(rsp_data.sound_cue));
               check_field("publish_valid", 32'(want.publish_valid),
                           32'(rsp_data.publish_valid));
               check_field("publish_event", 32'(want.publish_event),
                           32'(rsp_data.publish_event));
               check_field("publish_mode", 32'(want.publish_mode), 32'(rsp_data.publish_mode));
               check_field("publish_card", want.publish_card, rsp_data.publish_card);
               check_field("queue_dropped", 32'(want.queue_dropped),
                           32'(rsp_data.queue_dropped));
               checked++;
            end
         end
      end
      waiting = predicted_ticks.size();
   end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: door access controller test
// Drives millisecond ticks through the controller under several timer
// settings (reset values, all zero, all ones, short random timers and random
// timers with the fastest heartbeat and publish), first a directed walk through
// every mode, then random access, button, remote and denial sequences mixed
// with noise. Both channels idle at random; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import dac_pkg::*;

   logic           clock;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_type        req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_type        rsp_data;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [RIW-1:0] csr_index = '0;
   logic [RDW-1:0] csr_data  = '0;

   int             fail_count, waiting, checked, published, dropped_ticks;
   int             sent;
   int             settings_used;
   int             stall_left;
   logic           no_idle = 1'b0;
   logic [RDW-1:0] cfg [NREG];

   door_access_controller uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dac_tick_checker tick_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .waiting       (waiting),
      .checked       (checked),
      .published     (published),
      .dropped_ticks (dropped_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #9_000_000;
      $display("FAIL");
      $finish;
   end

   // mostly short idle spells, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   // response back-pressure in runs
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (no_idle || $urandom_range(99) < 60) begin
         rsp_stall  <= 1'b0;
         stall_left = $urandom_range(1, 30);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left = idle_len();
      end
   end

   // hold a request until taken, then maybe leave a gap
   task automatic send(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      gap = (!no_idle && $urandom_range(99) < 25) ? idle_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop requesting and wait for every response
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (waiting != 0);
      @(posedge clock);
   endtask

   // write all timers from cfg, one after another
   task automatic program_timers();
      csr_valid <= 1'b1;
      for (int i = 0; i < NREG; i++) begin
         csr_index <= RIW'(i);
         csr_data  <= cfg[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic req_type make_item(input bit door, input bit card, input bit valid,
                                         input logic [31:0] id, input bit button,
                                         input bit remote, input bit status);
      req_type item;
      item.door_open      = door;
      item.card_present   = card;
      item.card_valid     = valid;
      item.card_id        = id;
      item.button_press   = button;
      item.remote_open    = remote;
      item.status_request = status;
      return item;
   endfunction

   // no card, random junk on the idle card fields, the odd remote or status command
   function automatic req_type quiet_item(input bit door);
      return make_item(door, 1'b0, 1'($urandom_range(1)), $urandom(), 1'b0,
                       $urandom_range(99) < 2, $urandom_range(99) < 4);
   endfunction

   task automatic send_quiet(input bit door, input int count);
      repeat (count) send(quiet_item(door));
   endtask

   // long timers are cut short so a sequence stays brief
   function automatic int span(input logic [RDW-1:0] v);
      return (v > 40) ? 40 : int'(v);
   endfunction

   // valid card, lock release, door opened and shut or left to time out
   task automatic access_run();
      send(make_item(1'b0, 1'b1, 1'b1, $urandom(), 1'b0, 1'b0, 1'b0));
      send_quiet(1'b0, span(cfg[REG_LOCK_DELAY]) + $urandom_range(2));
      if ($urandom_range(3) == 0) begin
         send_quiet(1'b0, span(cfg[REG_DOOR_WAIT]) + 1);
      end else begin
         send_quiet(1'b1, $urandom_range(1, 3));
         send_quiet(1'b0, span(cfg[REG_SETTLE]) + $urandom_range(2));
      end
   endtask

   // button or remote open, then a door cycle or the window running out
   task automatic temp_run();
      if ($urandom_range(1) == 0) begin
         send(make_item(1'b0, 1'b0, 1'b0, $urandom(), 1'b1, 1'b0, 1'b0));
      end else begin
         send(make_item(1'b0, 1'b0, 1'b0, $urandom(), 1'b0, 1'b1, 1'b0));
         send_quiet(1'b0, 1);
      end
      send_quiet(1'b0, $urandom_range(2));
      if ($urandom_range(2) == 0) begin
         send_quiet(1'b0, span(cfg[REG_OPEN_TIMEOUT]) + 1);
      end else begin
         send_quiet(1'b1, $urandom_range(1, 3));
         send_quiet(1'b0, span(cfg[REG_SETTLE]) + $urandom_range(2));
      end
   endtask

   // unknown card, then wait it out or force the door
   task automatic deny_run();
      send(make_item(1'b0, 1'b1, 1'b0, $urandom(), 1'b0, 1'b0, 1'b0));
      if ($urandom_range(1) == 0) begin
         send_quiet(1'b0, span(cfg[REG_DENY_HOLD]) + 1);
      end else begin
         send_quiet(1'b1, $urandom_range(1, 3));
         send_quiet(1'b0, 1);
      end
   endtask

   // loosely biased ticks with a sticky door, some fully random
   task automatic noise_run(input int count);
      logic       door_now;
      logic [63:0] raw;
      req_type    item;
      door_now = 1'b0;
      repeat (count) begin
         if ($urandom_range(99) < 15) door_now = ~door_now;
         item = make_item(door_now, $urandom_range(99) < 8, 1'($urandom_range(1)), $urandom(),
                          $urandom_range(99) < 5, $urandom_range(99) < 5,
                          $urandom_range(99) < 5);
         if ($urandom_range(99) < 5) begin
            raw  = {$urandom(), $urandom()};
            item = raw[$bits(req_type)-1:0];
         end
         send(item);
      end
      send_quiet(1'b0, 1);
   endtask

   task automatic random_phase(input int budget);
      int first;
      int pick;
      first = sent;
      while (sent - first < budget) begin
         pick = $urandom_range(99);
         if (pick < 40) access_run();
         else if (pick < 55) temp_run();
         else if (pick < 65) deny_run();
         else noise_run($urandom_range(4, 15));
      end
      drain();
   endtask

   // short random timers
   task automatic short_timers();
      cfg[REG_LOCK_DELAY]   = RDW'($urandom_range(6));
      cfg[REG_DOOR_WAIT]    = RDW'($urandom_range(8));
      cfg[REG_DENY_HOLD]    = RDW'($urandom_range(6));
      cfg[REG_OPEN_TIMEOUT] = RDW'($urandom_range(8));
      cfg[REG_SETTLE]       = RDW'($urandom_range(6));
      cfg[REG_SETTLE_MAX]   = RDW'($urandom_range(8));
      cfg[REG_HEARTBEAT]    = RDW'($urandom_range(1, 40));
      cfg[REG_PUBLISH]      = RDW'($urandom_range(1, 5));
      program_timers();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset timers: first door report, alarm, remote and status in alarm,
      // denial then forced door, grant; the slow publish fills the queue
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b1));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0));
      drain();

      // short timers: full access cycle, remote open held over the settle and its
      // door cycle, then card, button and forced door in one tick
      cfg[REG_LOCK_DELAY]   = 24'd2;
      cfg[REG_DOOR_WAIT]    = 24'd3;
      cfg[REG_DENY_HOLD]    = 24'd2;
      cfg[REG_OPEN_TIMEOUT] = 24'd3;
      cfg[REG_SETTLE]       = 24'd2;
      cfg[REG_SETTLE_MAX]   = 24'd4;
      cfg[REG_HEARTBEAT]    = 24'd9;
      cfg[REG_PUBLISH]      = 24'd1;
      program_timers();
      send(make_item(1'b0, 1'b1, 1'b1, 32'h8000_0001, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      send(make_item(1'b1, 1'b1, 1'b0, 32'h5A5A_A5A5, 1'b1, 1'b0, 1'b0));
      send(make_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0));
      drain();

      // all timers zero: every interval fires on every tick
      for (int i = 0; i < NREG; i++) cfg[i] = '0;
      program_timers();
      random_phase(150);

      // all timers at maximum: nothing times out, publish never pops
      for (int i = 0; i < NREG; i++) cfg[i] = '1;
      program_timers();
      random_phase(100);

      // short random timers, one phase with no idling at all
      for (int p = 0; p < 5; p++) begin
         no_idle = (p == 2);
         short_timers();
         random_phase(260);
      end
      no_idle = 1'b0;

      // fastest heartbeat and publish with longer access timers
      for (int i = 0; i < NREG; i++) cfg[i] = RDW'($urandom_range(30));
      cfg[REG_HEARTBEAT] = 24'd1;
      cfg[REG_PUBLISH]   = 24'd1;
      program_timers();
      random_phase(300);

      repeat (8) @(posedge clock);
      $display("%0d requests over %0d timer settings, reset values, zero and maximum included",
               sent, settings_used + 1);
      $display("%0d responses compared, %0d events published, %0d ticks with a lost event",
               checked, published, dropped_ticks);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
